[rtl/tsmf_pkg.sv]
// ----------------------------------------------------------------------------
// tsmf_pkg
// Shared widths, register codes, reset values and sequencer states of the stereo/mono flipper.
// ----------------------------------------------------------------------------
package tsmf_pkg;

    localparam int SAMPLE_BITS_DEF  = 24;
    localparam int COUNTER_BITS_DEF = 28;

    localparam int HP_BITS       = 27;
    localparam int FL_BITS       = 16;
    localparam int CFG_IDX_BITS  = 8;
    localparam int CFG_DATA_BITS = 27;
    localparam int FRAC_BITS     = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_HALF_PERIOD = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_FADE_LENGTH = CFG_IDX_BITS'(1);

    localparam logic [HP_BITS-1:0] HP_RESET = HP_BITS'(2880000);
    localparam logic [FL_BITS-1:0] FL_RESET = FL_BITS'(4800);

    localparam logic [FRAC_BITS:0] UNITY_Q16 = {1'b1, {FRAC_BITS{1'b0}}};

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SETUP = 7'b0000010,
        ST_DIV   = 7'b0000100,
        ST_MUL_S = 7'b0001000,
        ST_MUL_L = 7'b0010000,
        ST_MUL_R = 7'b0100000,
        ST_FIN   = 7'b1000000
    } state_t;

endpackage

[rtl/timed_stereo_mono_flipper.sv]
// ----------------------------------------------------------------------------
// timed_stereo_mono_flipper
// Wrapping sample counter switching stereo and mono with linear crossfades.
// ----------------------------------------------------------------------------
// Sequence: an accepted beat passes through setup, the radix-2 fade-fraction
// divider (only inside a fade), the sum, left and right multiply steps and a
// finish state that waits for the output to be free. The sequencer and its
// single shared multiplier hold one item at a time.
// Reset: asynchronous, clears counter and handshake state, registers to
// their defaults.
module timed_stereo_mono_flipper
    import tsmf_pkg::*;
#(
    parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
    parameter int COUNTER_BITS = COUNTER_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] left_in,
    input  logic signed [SAMPLE_BITS-1:0] right_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out
);

    localparam int CW  = (COUNTER_BITS > HP_BITS + 1) ? COUNTER_BITS : HP_BITS + 1;
    localparam int PW  = SAMPLE_BITS + FRAC_BITS + 3;
    localparam int AW  = PW + 1;
    localparam int DCW = $clog2(FRAC_BITS);

    state_t state_reg, state_next;

    logic [HP_BITS-1:0]      hp_reg;
    logic [FL_BITS-1:0]      fl_reg;
    logic [COUNTER_BITS-1:0] cnt_reg;

    logic signed [SAMPLE_BITS-1:0] l_reg, r_reg, lres_reg;
    logic signed [SAMPLE_BITS-1:0] lout_reg, rout_reg;
    logic                          out_valid_reg;

    logic [FRAC_BITS:0]   m_reg;
    logic                 inv_reg;
    logic [FRAC_BITS:0]   rem_reg;
    logic [FRAC_BITS-1:0] q_reg;
    logic [DCW-1:0]       div_cnt_reg;

    logic signed [PW-1:0] prod_reg, psum_reg;

    // counter step
    logic [COUNTER_BITS-1:0] cnt_inc;
    logic                    cnt_wrap;

    // phase decode
    logic [CW-1:0]        t_ext, hp_ext, fl_ext, e_ext;

    // divider step
    logic [FRAC_BITS:0]   rem_dbl;
    logic                 rem_ge;
    logic [FRAC_BITS-1:0] q_next;

    // shared multiplier
    logic signed [SAMPLE_BITS:0] mul_a;
    logic signed [FRAC_BITS+1:0] mul_b;
    logic signed [PW-1:0]        mul_p;
    logic [FRAC_BITS:0]          w_val;
    logic signed [AW-1:0]        acc;
    logic signed [SAMPLE_BITS-1:0] acc_res;

    logic out_free;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign left_out  = lout_reg;
    assign right_out = rout_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign cnt_inc  = cnt_reg + 1'b1;
    assign cnt_wrap = CW'(cnt_inc) > CW'({hp_reg, 1'b0});

    assign t_ext  = CW'(cnt_reg);
    assign hp_ext = CW'(hp_reg);
    assign fl_ext = CW'(fl_reg);
    assign e_ext  = t_ext - hp_ext;

    assign rem_dbl = {rem_reg[FRAC_BITS-1:0], 1'b0};
    assign rem_ge  = rem_dbl >= {1'b0, fl_reg};
    assign q_next  = {q_reg[FRAC_BITS-2:0], rem_ge};

    assign w_val = UNITY_Q16 - m_reg;

    always_comb
    begin
        mul_a = (SAMPLE_BITS+1)'(l_reg) + (SAMPLE_BITS+1)'(r_reg);
        mul_b = $signed({1'b0, m_reg});
        case (state_reg)
            ST_MUL_L:
            begin
                mul_a = (SAMPLE_BITS+1)'(l_reg);
                mul_b = $signed({1'b0, w_val});
            end
            ST_MUL_R:
            begin
                mul_a = (SAMPLE_BITS+1)'(r_reg);
                mul_b = $signed({1'b0, w_val});
            end
            default:
            begin
            end
        endcase
    end

    assign mul_p   = PW'(mul_a * mul_b);
    assign acc     = (AW'(prod_reg) <<< 1) + AW'(psum_reg);
    assign acc_res = acc[SAMPLE_BITS+FRAC_BITS:FRAC_BITS+1];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_SETUP;
            ST_SETUP:
            begin
                if ((t_ext < hp_ext && t_ext < fl_ext) ||
                    (t_ext >= hp_ext && e_ext < fl_ext))
                    state_next = ST_DIV;
                else
                    state_next = ST_MUL_S;
            end
            ST_DIV:   if (div_cnt_reg == '0) state_next = ST_MUL_S;
            ST_MUL_S: state_next = ST_MUL_L;
            ST_MUL_L: state_next = ST_MUL_R;
            ST_MUL_R: state_next = ST_FIN;
            ST_FIN:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hp_reg        <= HP_RESET;
            fl_reg        <= FL_RESET;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_HALF_PERIOD: hp_reg <= cfg_data[HP_BITS-1:0];
                    REG_FADE_LENGTH: fl_reg <= cfg_data[FL_BITS-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == ST_IDLE && in_valid)
                cnt_reg <= cnt_wrap ? '0 : cnt_inc;
            if (state_reg == ST_FIN && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    l_reg <= left_in;
                    r_reg <= right_in;
                end
            end
            ST_SETUP:
            begin
                q_reg       <= '0;
                div_cnt_reg <= DCW'(FRAC_BITS - 1);
                if (t_ext < hp_ext)
                begin
                    inv_reg <= 1'b1;
                    rem_reg <= {1'b0, t_ext[FRAC_BITS-1:0]};
                    m_reg   <= '0;
                end
                else
                begin
                    inv_reg <= 1'b0;
                    rem_reg <= {1'b0, e_ext[FRAC_BITS-1:0]};
                    m_reg   <= UNITY_Q16;
                end
            end
            ST_DIV:
            begin
                rem_reg     <= rem_ge ? rem_dbl - {1'b0, fl_reg} : rem_dbl;
                q_reg       <= q_next;
                div_cnt_reg <= div_cnt_reg - 1'b1;
                if (div_cnt_reg == '0)
                    m_reg <= inv_reg ? UNITY_Q16 - {1'b0, q_next} : {1'b0, q_next};
            end
            ST_MUL_S: psum_reg <= mul_p;
            ST_MUL_L: prod_reg <= mul_p;
            ST_MUL_R:
            begin
                lres_reg <= acc_res;
                prod_reg <= mul_p;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    lout_reg <= lres_reg;
                    rout_reg <= acc_res;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

[rtl/tsmf_checker.sv]
// ----------------------------------------------------------------------------
// tsmf_checker
// Port-level checks of the stereo/mono flipper, bound to the top level.
// ----------------------------------------------------------------------------
module tsmf_checker
    import tsmf_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [SAMPLE_BITS-1:0] left_out,
    input logic signed [SAMPLE_BITS-1:0] right_out
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(left_out) && $stable(right_out))
        else $error("output beat changed while stalled");

    // sequencer stays busy after accepting a beat
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)
        else $error("input accepted during processing");

    // a new result only comes out of a busy sequencer
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without work in progress");

endmodule

bind timed_stereo_mono_flipper tsmf_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_tsmf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .left_out  (left_out),
    .right_out (right_out)
);

[tb/sv/timed_stereo_mono_flipper_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timed_stereo_mono_flipper_tb
// Drives stereo sample pairs through the flipper under many settings of the
// half period and the fade length: defaults, tiny periods that reach every
// region (steady stereo, fade into mono, steady mono, fade back, wrap),
// zero fade, zero half period, all-ones registers and a shrink of the period
// below the running count. A scoreboard predicts each output pair from its
// own copy of the counter and registers and checks every beat in order,
// while both handshake sides idle and stall at random.
// ----------------------------------------------------------------------------
module timed_stereo_mono_flipper_tb;
    import tsmf_pkg::*;

    localparam int SW          = SAMPLE_BITS_DEF;
    localparam int CW          = COUNTER_BITS_DEF;
    localparam int TOTAL_ITEMS = 750;
    localparam int SETTLE      = 32;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PRINT_LIMIT = 40;

    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_LO = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED_HI = '1;

    typedef struct packed {
        logic signed [SW-1:0] left;
        logic signed [SW-1:0] right;
    } stereo_pair_t;

    class flip_scoreboard;
        logic [HP_BITS-1:0] half_period;
        logic [FL_BITS-1:0] fade_length;
        logic [CW-1:0]      sample_count;
        stereo_pair_t       expected_q[$];
        int errors;
        int checked;
        int accepted;
        int n_stereo;
        int n_mono;
        int n_fade;

        function new();
            half_period  = HP_RESET;
            fade_length  = FL_RESET;
            sample_count = '0;
            errors   = 0;
            checked  = 0;
            accepted = 0;
            n_stereo = 0;
            n_mono   = 0;
            n_fade   = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report_mismatch(string msg);
            if (errors < PRINT_LIMIT)
                $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        function void write_reg(logic [CFG_IDX_BITS-1:0] idx,
                                logic [CFG_DATA_BITS-1:0] data);
            if (idx == REG_HALF_PERIOD)
                half_period = data[HP_BITS-1:0];
            else if (idx == REG_FADE_LENGTH)
                fade_length = data[FL_BITS-1:0];
        endfunction

        // out = floor((2*x*(1-m) + s*m) / 2), m in Q1.16
        function logic [SW-1:0] mix(longint x, longint s, longint m);
            longint acc;
            acc = 2 * x * (longint'(UNITY_Q16) - m) + s * m;
            acc = acc >>> (FRAC_BITS + 1);
            return acc[SW-1:0];
        endfunction

        function void note_input(logic signed [SW-1:0] l, logic signed [SW-1:0] r);
            logic [CW-1:0] nxt;
            longint t;
            longint hp;
            longint fl;
            longint e;
            longint m;
            longint s;
            stereo_pair_t p;
            nxt = sample_count + 1'b1;
            if (longint'(nxt) > 2 * longint'(half_period))
                nxt = '0;
            sample_count = nxt;
            t  = longint'(nxt);
            hp = longint'(half_period);
            fl = longint'(fade_length);
            if (t < hp) begin
                if (t < fl)
                    m = longint'(UNITY_Q16) - (t << FRAC_BITS) / fl;
                else
                    m = 0;
            end
            else begin
                e = t - hp;
                if (e < fl)
                    m = (e << FRAC_BITS) / fl;
                else
                    m = longint'(UNITY_Q16);
            end
            if (m == 0)
                n_stereo++;
            else if (m == longint'(UNITY_Q16))
                n_mono++;
            else
                n_fade++;
            s = longint'(l) + longint'(r);
            p.left  = mix(longint'(l), s, m);
            p.right = mix(longint'(r), s, m);
            expected_q.push_back(p);
            accepted++;
        endfunction

        task check_result(logic signed [SW-1:0] l, logic signed [SW-1:0] r);
            stereo_pair_t want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("output beat %0d/%0d with nothing pending", l, r));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (l !== want.left)
                report_mismatch($sformatf("beat %0d left_out %0d, want %0d",
                                          checked, l, want.left));
            if (r !== want.right)
                report_mismatch($sformatf("beat %0d right_out %0d, want %0d",
                                          checked, r, want.right));
        endtask
    endclass

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data  = '0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    logic signed [SW-1:0]     left_in   = '0;
    logic signed [SW-1:0]     right_in  = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [SW-1:0]     left_out;
    logic signed [SW-1:0]     right_out;

    flip_scoreboard sb = new();

    bit tx_idle_en  = 1'b1;
    bit rx_idle_en  = 1'b1;
    int rx_hold     = 0;
    int cycle_count = 0;
    int settings    = 0;

    timed_stereo_mono_flipper dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .left_in   (left_in),
        .right_in  (right_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .left_out  (left_out),
        .right_out (right_out)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, sb.pending());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && cfg_valid && cfg_ready)
            sb.write_reg(cfg_index, cfg_data);
        if (rst_n && in_valid && in_ready)
            sb.note_input(left_in, right_in);
        if (rst_n && out_valid && out_ready)
            sb.check_result(left_out, right_out);
    end

    function automatic int pick_gap(bit en);
        int r;
        r = $urandom_range(0, 99);
        if (!en || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver back-pressure
    always @(posedge clk)
    begin
        if (rx_hold != 0) begin
            rx_hold   <= rx_hold - 1;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= 1'b1;
            if (rx_idle_en && $urandom_range(0, 3) == 0)
                rx_hold <= pick_gap(1'b1);
        end
    end

    function automatic logic [SW-1:0] extreme_value(int k);
        case (k % 8)
            0:       return {1'b0, {(SW-1){1'b1}}};
            1:       return {1'b1, {(SW-1){1'b0}}};
            2:       return '0;
            3:       return '1;
            4:       return SW'(1);
            5:       return {(SW/2){2'b01}};
            6:       return {(SW/2){2'b10}};
            default: return {1'b1, {(SW-2){1'b0}}, 1'b1};
        endcase
    endfunction

    task automatic send_pair(input logic [SW-1:0] l, input logic [SW-1:0] r);
        int gap;
        gap = pick_gap(tx_idle_en);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        left_in  <= l;
        right_in <= r;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(input logic [CFG_DATA_BITS-1:0] hp_data,
                            input logic [CFG_DATA_BITS-1:0] fl_data);
        drain();
        write_cfg(REG_HALF_PERIOD, hp_data);
        write_cfg(REG_FADE_LENGTH, fl_data);
        settings++;
    endtask

    task automatic send_extremes(input int n, input int base);
        for (int k = 0; k < n; k++)
            send_pair(extreme_value(base + k), extreme_value(3 * (base + k) + 1));
    endtask

    initial
    begin
        int n;
        int r;
        logic [CFG_DATA_BITS-1:0] hp_data;
        logic [FL_BITS-1:0]       fl_val;
        logic [CFG_DATA_BITS-1:0] fl_data;
        logic [SW-1:0]            l;
        logic [SW-1:0]            rr;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: start of the fade back into stereo
        settings++;
        send_extremes(8, 0);
        // short period: every region and the wrap to zero
        set_regs(CFG_DATA_BITS'(3), CFG_DATA_BITS'(2));
        send_extremes(9, 2);
        set_regs(CFG_DATA_BITS'(0), CFG_DATA_BITS'(3));
        send_extremes(2, 5);
        set_regs(CFG_DATA_BITS'(2), CFG_DATA_BITS'(0));
        send_extremes(5, 1);
        drain();
        write_cfg(REG_UNUSED_HI, '1);
        write_cfg(REG_UNUSED_LO, '1);
        set_regs('1, '1);
        send_extremes(10, 3);
        // count now above twice the new period
        set_regs(CFG_DATA_BITS'(2), CFG_DATA_BITS'(1));
        send_extremes(3, 6);

        while (sb.accepted < TOTAL_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                hp_data = CFG_DATA_BITS'($urandom_range(1, 40));
            else if (r < 85)
                hp_data = CFG_DATA_BITS'($urandom_range(41, 400));
            else if (r < 95)
                hp_data = CFG_DATA_BITS'($urandom_range(0, 2));
            else
                hp_data = CFG_DATA_BITS'($urandom());
            r = $urandom_range(0, 99);
            if (r < 60)
                fl_val = FL_BITS'($urandom_range(1, 20));
            else if (r < 80)
                fl_val = '0;
            else if (r < 90)
                fl_val = FL_BITS'($urandom_range(21, 300));
            else
                fl_val = FL_BITS'($urandom());
            if ($urandom_range(0, 1) == 1)
                fl_data = CFG_DATA_BITS'({$urandom(), fl_val});
            else
                fl_data = CFG_DATA_BITS'(fl_val);
            set_regs(hp_data, fl_data);
            if ($urandom_range(0, 7) == 0)
                write_cfg(CFG_IDX_BITS'($urandom_range(2, 255)), CFG_DATA_BITS'($urandom()));
            tx_idle_en = $urandom_range(0, 3) != 0;
            rx_idle_en <= $urandom_range(0, 3) != 0;
            n = $urandom_range(20, 70);
            for (int k = 0; k < n; k++) begin
                if ($urandom_range(0, 99) < 85) begin
                    l  = SW'($urandom());
                    rr = SW'($urandom());
                end
                else begin
                    l  = extreme_value($urandom_range(0, 7));
                    rr = extreme_value($urandom_range(0, 7));
                end
                send_pair(l, rr);
                if ($urandom_range(0, 49) == 0)
                    drain();
            end
        end

        drain();
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        $display("Ran %0d sample pairs under %0d register settings, %0d results compared.",
                 sb.accepted, settings, sb.checked);
        $display("Mix: %0d pass-through, %0d full mono, %0d mid-crossfade, %0d errors.",
                 sb.n_stereo, sb.n_mono, sb.n_fade, sb.errors);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
